// ----- hdl/sis_pkg.sv -----
// Shared types and constants for the sorted insert stack.
// Holds operation, status, state and cell control codes; no dependencies.
package sis_pkg;

    // Operation selector carried in the input tuser.
    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_SPUSH   = 2'd2,
        OP_REVERSE = 2'd3
    } t_opcode;

    // Result status carried in the output tuser.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_ROUNDS
    } t_state;

    // What every cell does in the current cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_TAG,
        CELL_SWAP
    } t_cell_op;

    // Control bundle broadcast from the controller to the row of cells.
    typedef struct packed {
        t_cell_op op;
        logic     phase;   // parity of the lower cell of each active pair
        logic     by_tag;  // order by position tag instead of by value
    } t_cell_ctl;

    // Value returned by a pop on an empty stack.
    localparam logic signed [31:0] EMPTY_MARK = -32'sd999;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

endpackage

// ----- hdl/sis_cell.sv -----
// One stack slot: holds a word and a position tag, shifts with its neighbors
// and runs its half of an odd-even compare-exchange. Depends on sis_pkg.
module sis_cell #(
    parameter int INDEX = 0,
    parameter int DEPTH = 32
) (
    input  logic                               i_clk,
    input  sis_pkg::t_cell_ctl                 i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]         i_count,
    input  logic signed [sis_pkg::DATA_W-1:0]  i_lo_data,
    input  logic [$clog2(DEPTH)-1:0]           i_lo_tag,
    input  logic                               i_lo_swap,
    input  logic signed [sis_pkg::DATA_W-1:0]  i_hi_data,
    input  logic [$clog2(DEPTH)-1:0]           i_hi_tag,
    output logic                               o_swap,
    output logic signed [sis_pkg::DATA_W-1:0]  o_data,
    output logic [$clog2(DEPTH)-1:0]           o_tag
);
    import sis_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(DEPTH);
    localparam logic PARITY = 1'(INDEX % 2);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [TW-1:0]            r_tag;
    logic [TW-1:0]            n_tag;
    logic                     w_active;
    logic                     w_less;

    // The pair with the cell above is live only when both slots hold entries.
    assign w_active = (CW'(INDEX + 1) < i_count);
    assign w_less   = i_ctl.by_tag ? (r_tag < i_hi_tag) : (r_data < i_hi_data);
    assign o_swap   = (i_ctl.op == CELL_SWAP) && (i_ctl.phase == PARITY)
                      && w_active && w_less;

    // Next slot contents.
    always_comb begin
        n_data = r_data;
        n_tag  = r_tag;
        unique case (i_ctl.op)
            CELL_PUSH: begin
                n_data = i_lo_data;
            end
            CELL_POP: begin
                n_data = i_hi_data;
            end
            CELL_TAG: begin
                n_tag = TW'(INDEX);
            end
            CELL_SWAP: begin
                if (o_swap) begin
                    n_data = i_hi_data;
                    n_tag  = i_hi_tag;
                end else if (i_lo_swap) begin
                    n_data = i_lo_data;
                    n_tag  = i_lo_tag;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tag  <= n_tag;
    end

    assign o_data = r_data;
    assign o_tag  = r_tag;

endmodule

// ----- hdl/sis_ctrl.sv -----
// Controller for the sorted insert stack: handshakes, fill count, round
// sequencer for sort and reverse, and the result register. Depends on sis_pkg.
module sis_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sis_pkg::t_opcode                   i_opcode,
    input  logic signed [sis_pkg::DATA_W-1:0]  i_top_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [sis_pkg::DATA_W-1:0]  o_popped,
    output sis_pkg::t_status                   o_status,
    output logic [sis_pkg::COUNT_W-1:0]        o_entry_count,
    output sis_pkg::t_cell_ctl                 o_ctl,
    output logic [$clog2(DEPTH+1)-1:0]         o_count
);
    import sis_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(DEPTH);

    t_state                r_state;
    t_state                n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [TW-1:0]         r_round;
    logic [TW-1:0]         n_round;
    logic                  r_by_tag;
    logic                  n_by_tag;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic signed [DATA_W-1:0] r_popped;
    logic signed [DATA_W-1:0] n_popped;
    t_status               r_status;
    t_status               n_status;
    logic [COUNT_W-1:0]    r_entry_count;
    logic [COUNT_W-1:0]    n_entry_count;
    logic                  w_accept;
    logic                  w_full;
    logic                  w_empty;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Next state, cell commands and result fields.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_round       = r_round;
        n_by_tag      = r_by_tag;
        n_popped      = r_popped;
        n_status      = r_status;
        n_entry_count = r_entry_count;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_ctl.op      = CELL_HOLD;
        o_ctl.phase   = r_round[0];
        o_ctl.by_tag  = r_by_tag;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_popped    = '0;
                    n_status    = ST_DONE;
                    n_round     = '0;
                    unique case (i_opcode)
                        OP_PUSH, OP_SPUSH: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ctl.op = CELL_PUSH;
                                n_count  = r_count + CW'(1);
                                if (i_opcode == OP_SPUSH) begin
                                    n_state  = S_ROUNDS;
                                    n_by_tag = 1'b0;
                                end
                            end
                        end
                        OP_POP: begin
                            if (w_empty) begin
                                n_popped = EMPTY_MARK;
                                n_status = ST_EMPTY;
                            end else begin
                                o_ctl.op = CELL_POP;
                                n_popped = i_top_data;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        OP_REVERSE: begin
                            o_ctl.op = CELL_TAG;
                            n_state  = S_ROUNDS;
                            n_by_tag = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                    n_entry_count = COUNT_W'(n_count);
                end
            end
            S_ROUNDS: begin
                // One odd-even transposition round per cycle, DEPTH rounds.
                o_ctl.op = CELL_SWAP;
                n_round  = r_round + TW'(1);
                if (r_round == TW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload and ordering mode.
    always_ff @(posedge i_clk) begin
        r_by_tag      <= n_by_tag;
        r_popped      <= n_popped;
        r_status      <= n_status;
        r_entry_count <= n_entry_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_popped      = r_popped;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_count       = r_count;

endmodule

// ----- hdl/sorted_insert_stack.sv -----
// Push and pop register their result beat, shown in the cycle after acceptance.
// Sorted push and reverse also answer in the cycle after acceptance, but the row of cells
// then runs DEPTH odd-even compare-exchange rounds, and no new beat is taken until the
// rounds end; push and pop take one beat per cycle while result beats are read.
// Reset (synchronous, active low) empties the stack; slot words are not cleared.
// Top level: a controller and a row of DEPTH cells. Depends on sis_pkg.
module sorted_insert_stack #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value[31:0]
    input  logic [1:0]  i_s_axis_tuser,   // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // popped_value[31:0], entry_count[37:32], zero pad
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);
    import sis_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = $clog2(DEPTH);

    t_cell_ctl                w_ctl;
    logic [CW-1:0]            w_count;
    logic signed [DATA_W-1:0] w_data [DEPTH];
    logic [TW-1:0]            w_tag  [DEPTH];
    logic                     w_swap [DEPTH];
    logic signed [DATA_W-1:0] w_popped;
    t_status                  w_status;
    logic [COUNT_W-1:0]       w_entry_count;

    // Sequencer and result register.
    sis_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_opcode     (t_opcode'(i_s_axis_tuser)),
        .i_top_data   (w_data[0]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_popped     (w_popped),
        .o_status     (w_status),
        .o_entry_count(w_entry_count),
        .o_ctl        (w_ctl),
        .o_count      (w_count)
    );

    // Row of cells; cell 0 is the top of the stack.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_lo_data;
        logic [TW-1:0]            w_lo_tag;
        logic                     w_lo_swap;
        logic signed [DATA_W-1:0] w_hi_data;
        logic [TW-1:0]            w_hi_tag;

        if (g == 0) begin : g_first
            assign w_lo_data = $signed(i_s_axis_tdata);
            assign w_lo_tag  = '0;
            assign w_lo_swap = 1'b0;
        end else begin : g_inner_lo
            assign w_lo_data = w_data[g-1];
            assign w_lo_tag  = w_tag[g-1];
            assign w_lo_swap = w_swap[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_hi_data = w_data[g];
            assign w_hi_tag  = w_tag[g];
        end else begin : g_inner_hi
            assign w_hi_data = w_data[g+1];
            assign w_hi_tag  = w_tag[g+1];
        end

        sis_cell #(
            .INDEX(g),
            .DEPTH(DEPTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_count  (w_count),
            .i_lo_data(w_lo_data),
            .i_lo_tag (w_lo_tag),
            .i_lo_swap(w_lo_swap),
            .i_hi_data(w_hi_data),
            .i_hi_tag (w_hi_tag),
            .o_swap   (w_swap[g]),
            .o_data   (w_data[g]),
            .o_tag    (w_tag[g])
        );
    end

    // Output beat packing.
    assign o_m_axis_tdata = {2'b00, w_entry_count, w_popped};
    assign o_m_axis_tuser = w_status;

endmodule

// ----- hdl/sis_checker.sv -----
// Port-level checker for the sorted insert stack, bound to the top level.
// Depends on sis_pkg.
module sis_checker #(
    parameter int DEPTH = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import sis_pkg::*;

    // No result beat is pending right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // A pop on an empty stack reports the empty mark and no entries.
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_EMPTY
        |-> o_m_axis_tdata[31:0] == EMPTY_MARK && o_m_axis_tdata[37:32] == '0)
        else $error("bad empty-pop result");

    // A rejected push reports a full stack.
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == ST_FULL
        |-> o_m_axis_tdata[37:32] == COUNT_W'(DEPTH) && o_m_axis_tdata[31:0] == '0)
        else $error("bad full-push result");

    // Input is refused while a result beat waits unread.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while result stalled");

endmodule

bind sorted_insert_stack sis_checker #(.DEPTH(DEPTH)) u_sis_checker (.*);

// ----- sim/tb_sorted_insert_stack.sv -----
// Testbench for sorted_insert_stack: a directed table of stack operations, then weighted
// random operations, each result beat checked against a behavioral stack kept in the bench.
// Depends on sis_pkg and sorted_insert_stack from the hdl folder.
module tb_sorted_insert_stack;
    import sis_pkg::*;

    localparam int DEPTH         = 32;
    localparam int RANDOM_OPS    = 700;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_IDLE      = 10;
    localparam int REPORT_LIMIT  = 10;

    // One result beat, split into its fields.
    typedef struct packed {
        logic signed [31:0] popped;
        t_status            status;
        logic [5:0]         count;
    } t_stack_result;

    // One row of the directed table; a row repeats its operation reps times, adding
    // step to the value each time.
    typedef struct packed {
        t_opcode       op;
        logic [31:0]   val;
        logic [7:0]    reps;
        logic [31:0]   step;
        logic          typed;
        t_stack_result want;
    } t_op_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // value[31:0]
    logic [1:0]  i_s_axis_tuser = '0;   // opcode[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // popped_value[31:0], entry_count[37:32], zero pad
    logic [1:0]  o_m_axis_tuser;        // status[1:0]

    // Bench copy of the stack, bottom at index 0.
    logic signed [31:0] stack_words [DEPTH];
    int                 stack_fill = 0;

    t_stack_result awaited_results [$];
    t_op_row       op_table [$];
    int            mismatches = 0;
    int            cycles = 0;
    int            rx_stall = 0;
    int            rx_beats = 0;
    bit            rx_quiet = 1'b0;
    bit            tx_quiet = 1'b0;

    sorted_insert_stack #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_sorted_insert_stack: done, errors");
            $finish;
        end
    end

    // Apply one operation to the bench stack and return the result it should give.
    task automatic apply_stack_op(input t_opcode op, input logic signed [31:0] val,
                                  output t_stack_result res);
        int                 lo;
        int                 hi;
        int                 j;
        logic signed [31:0] key;
        res.popped = '0;
        res.status = ST_DONE;
        case (op)
            OP_PUSH, OP_SPUSH: begin
                if (stack_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    stack_words[stack_fill] = val;
                    stack_fill++;
                    // Insertion sort, rising from bottom to top.
                    if (op == OP_SPUSH) begin
                        for (int i = 1; i < stack_fill; i++) begin
                            key = stack_words[i];
                            j = i;
                            while (j > 0 && key < stack_words[j - 1]) begin
                                stack_words[j] = stack_words[j - 1];
                                j--;
                            end
                            stack_words[j] = key;
                        end
                    end
                end
            end
            OP_POP: begin
                if (stack_fill == 0) begin
                    res.popped = EMPTY_MARK;
                    res.status = ST_EMPTY;
                end else begin
                    stack_fill--;
                    res.popped = stack_words[stack_fill];
                end
            end
            default: begin
                lo = 0;
                hi = stack_fill;
                while (hi > lo + 1) begin
                    key = stack_words[lo];
                    stack_words[lo] = stack_words[hi - 1];
                    stack_words[hi - 1] = key;
                    lo++;
                    hi--;
                end
            end
        endcase
        res.count = stack_fill[5:0];
    endtask

    // Send one input beat after a random gap, then queue what it should return.
    task automatic send_op(input t_opcode op, input logic [31:0] val, input logic typed,
                           input t_stack_result want);
        int            gap;
        t_stack_result predicted;
        gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= val;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        apply_stack_op(op, val, predicted);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input t_opcode op, input logic [31:0] val, input int reps,
                           input logic [31:0] step, input logic typed,
                           input logic [31:0] popped, input t_status status, input int count);
        t_op_row row;
        row.op          = op;
        row.val         = val;
        row.reps        = reps[7:0];
        row.step        = step;
        row.typed       = typed;
        row.want.popped = popped;
        row.want.status = status;
        row.want.count  = count[5:0];
        op_table.push_back(row);
    endtask

    // Result side: random stalls on tready, and every accepted beat checked in order.
    always @(posedge i_clk) begin : result_side
        t_stack_result seen;
        t_stack_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                seen.popped = o_m_axis_tdata[31:0];
                seen.count  = o_m_axis_tdata[37:32];
                seen.status = t_status'(o_m_axis_tuser);
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected result beat: popped %0d status %0d count %0d",
                                 seen.popped, seen.status, seen.count);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.popped !== want.popped || seen.status !== want.status ||
                        seen.count !== want.count) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("result mismatch at cycle %0d: popped %0d/%0d",
                                     cycles, want.popped, seen.popped,
                                     " status %0d/%0d count %0d/%0d (expected/actual)",
                                     want.status, seen.status, want.count, seen.count);
                        end
                    end
                end
                rx_beats++;
                if (rx_beats % 40 == 0) begin
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                rx_stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            i_m_axis_tready <= (rx_stall == 0);
        end
    end

    initial begin
        t_op_row            row;
        t_stack_result      none;
        t_opcode            op;
        logic [31:0]        val;
        int                 lean;
        int                 pick;
        none = '0;

        // Directed table. Rows with typed set carry their expected result; the rest use
        // the bench stack.
        add_row(OP_POP,     32'd0,         1, 32'd0, 1'b1, EMPTY_MARK,   ST_EMPTY, 0);
        add_row(OP_REVERSE, 32'd0,         1, 32'd0, 1'b1, 32'd0,        ST_DONE,  0);
        add_row(OP_PUSH,    32'h7FFF_FFFF, 1, 32'd0, 1'b1, 32'd0,        ST_DONE,  1);
        add_row(OP_REVERSE, 32'hFFFF_FFFF, 1, 32'd0, 1'b1, 32'd0,        ST_DONE,  1);
        add_row(OP_POP,     32'hFFFF_FFFF, 1, 32'd0, 1'b1, 32'h7FFF_FFFF, ST_DONE, 0);
        add_row(OP_PUSH,    32'h8000_0000, 1, 32'd0, 1'b1, 32'd0,        ST_DONE,  1);
        add_row(OP_SPUSH,   32'h7FFF_FFFF, 1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_SPUSH,   32'hFFFF_FFFF, 1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_SPUSH,   32'd0,         1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_SPUSH,   32'h8000_0000, 1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_SPUSH,   32'd1,         1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_REVERSE, 32'd0,         1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_POP,     32'd0,         6, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_POP,     32'd0,         1, 32'd0, 1'b1, EMPTY_MARK,   ST_EMPTY, 0);
        // Fill to one below full with falling values, then sort the whole stack.
        add_row(OP_PUSH,    32'h7000_0000, 31, 32'hF8FF_FFFF, 1'b0, 32'd0, ST_DONE, 0);
        add_row(OP_SPUSH,   32'h5555_5555, 1, 32'd0, 1'b1, 32'd0,        ST_DONE,  32);
        add_row(OP_PUSH,    32'hAAAA_AAAA, 1, 32'd0, 1'b1, 32'd0,        ST_FULL,  32);
        add_row(OP_SPUSH,   32'h8000_0000, 1, 32'd0, 1'b1, 32'd0,        ST_FULL,  32);
        add_row(OP_REVERSE, 32'd0,         1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_POP,     32'd0,        32, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_POP,     32'd0,         1, 32'd0, 1'b1, EMPTY_MARK,   ST_EMPTY, 0);
        add_row(OP_SPUSH,   32'd3,         8, 32'hFFFF_FFFF, 1'b0, 32'd0, ST_DONE, 0);
        add_row(OP_PUSH,    32'd7,         5, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_SPUSH,   32'd7,         1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);
        add_row(OP_REVERSE, 32'd0,         1, 32'd0, 1'b0, 32'd0,        ST_DONE,  0);

        // Hold reset before the first operation.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (op_table[r]) begin
            row = op_table[r];
            for (int k = 0; k < row.reps; k++) begin
                send_op(row.op, row.val + row.step * k, row.typed, row.want);
            end
        end

        // Random part: blocks of operations that lean toward filling, draining or
        // neither, so that both the full and the empty stack come up often.
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 50 == 0) begin
                lean = $urandom_range(0, 2);
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            case (lean)
                0: op = pick < 45 ? OP_PUSH : pick < 80 ? OP_SPUSH :
                        pick < 92 ? OP_POP : OP_REVERSE;
                1: op = pick < 15 ? OP_PUSH : pick < 30 ? OP_SPUSH :
                        pick < 90 ? OP_POP : OP_REVERSE;
                default: op = pick < 30 ? OP_PUSH : pick < 55 ? OP_SPUSH :
                              pick < 85 ? OP_POP : OP_REVERSE;
            endcase
            // Values: mostly full random words, some small ones for ties, some extremes.
            pick = $urandom_range(0, 7);
            if (pick < 2) begin
                val = $urandom_range(0, 8) - 4;
            end else if (pick == 2) begin
                case ($urandom_range(0, 3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = 32'hFFFF_FFFF;
                    default: val = 32'd0;
                endcase
            end else begin
                val = $urandom;
            end
            send_op(op, val, 1'b0, none);
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain the remaining results, then allow for a last round of sorting.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_sorted_insert_stack: done, clean");
        end else begin
            $display("tb_sorted_insert_stack: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sis_pkg.sv
hdl/sis_cell.sv
hdl/sis_ctrl.sv
hdl/sorted_insert_stack.sv
hdl/sis_checker.sv
sim/tb_sorted_insert_stack.sv
